@@ rtl/vass_pkg.sv @@
// vass_pkg: shared constants and functions for the vertical acceleration safety shim
// no dependencies

package vass_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam logic [62:0] SATMAX = 63'h3FFF_FFFF_FFFF_FFFF;

    localparam logic [30:0] STEP_RST  = 31'd6554;
    localparam logic [31:0] AMIN_RST  = 32'hFFFB_0000;
    localparam logic [31:0] BOUND_RST = 32'd6553600;

    localparam logic [1:0] REG_STEP  = 2'd0;
    localparam logic [1:0] REG_AMIN  = 2'd1;
    localparam logic [1:0] REG_BOUND = 2'd2;

    // magnitude of a saturating signed value, bit 63 carries the sign
    function automatic logic [63:0] mag64(input logic signed [63:0] x);
        mag64 = x[63] ? (64'd0 - x) : x;
    endfunction

    function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > $signed({2'b00, SATMAX}))
            sadd = {1'b0, SATMAX};
        else if (s < -$signed({2'b00, SATMAX}))
            sadd = -$signed({1'b0, SATMAX});
        else
            sadd = s[63:0];
    endfunction

endpackage

@@ rtl/vass_mul.sv @@
// vass_mul: serial signed fixed-point multiplier, one multiplier bit a cycle
// depends on vass_pkg

module vass_mul #(
    parameter int FRAC_BITS = vass_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    output logic               done,
    output logic signed [63:0] p
);

    logic [127:0] acc_reg;
    logic [127:0] mcand_reg;
    logic [63:0]  mplr_reg;
    logic         neg_reg;
    logic [6:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;

    logic [127:0] shifted;
    logic [63:0]  mres;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                cnt_reg   <= '0;
                acc_reg   <= '0;
                mcand_reg <= {64'd0, vass_pkg::mag64(a)};
                mplr_reg  <= vass_pkg::mag64(b);
                neg_reg   <= a[63] ^ b[63];
            end else if (busy_reg) begin
                if (mplr_reg[0])
                    acc_reg <= acc_reg + mcand_reg;
                mcand_reg <= {mcand_reg[126:0], 1'b0};
                mplr_reg  <= {1'b0, mplr_reg[63:1]};
                cnt_reg   <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        shifted = acc_reg >> FRAC_BITS;
        if (shifted[127:62] != '0)
            mres = {1'b0, vass_pkg::SATMAX};
        else
            mres = {2'b00, shifted[61:0]};
        p = neg_reg ? (64'd0 - mres) : mres;
    end

    assign done = done_reg;

endmodule

@@ rtl/vass_div.sv @@
// vass_div: serial restoring divider for the braking distance term
// depends on vass_pkg

module vass_div #(
    parameter int FRAC_BITS = vass_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic        done,
    output logic [63:0] q
);

    localparam int QW = 64 + FRAC_BITS;

    logic [QW-1:0] dvd_reg;
    logic [QW-1:0] quo_reg;
    logic [64:0]   rem_reg;
    logic [63:0]   den_reg;
    logic [6:0]    cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [64:0] trial;

    assign trial = {rem_reg[63:0], dvd_reg[QW-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                dvd_reg  <= {num, {FRAC_BITS{1'b0}}};
                quo_reg  <= '0;
                rem_reg  <= '0;
                den_reg  <= den;
            end else if (busy_reg) begin
                dvd_reg <= {dvd_reg[QW-2:0], 1'b0};
                if (trial >= {1'b0, den_reg}) begin
                    rem_reg <= trial - {1'b0, den_reg};
                    quo_reg <= {quo_reg[QW-2:0], 1'b1};
                end else begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[QW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'(QW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (quo_reg[QW-1:62] != '0)
            q = {1'b0, vass_pkg::SATMAX};
        else
            q = {2'b00, quo_reg[61:0]};
    end

    assign done = done_reg;

endmodule

@@ rtl/vertical_accel_safety_shim_unit.sv @@
// vertical_accel_safety_shim_unit: top level, sequencer and registers
// per request: ten serial multiplies, one divide, then the S_FIN and S_OUT states; the
// divide is skipped when min_accel is not negative
// one request at a time, the next accepted the cycle after the result is taken
// aresetn synchronous active low clears state, registers take their reset values
// depends on vass_pkg, vass_mul, vass_div

module vertical_accel_safety_shim_unit #(
    parameter int FRAC_BITS = vass_pkg::FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // altitude, vertical_velocity, proposed_accel
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // granted_accel, rejected, reject_count, excess_sum, pad
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_DIV  = 4'd2;
    localparam logic [3:0] S_FIN  = 4'd3;
    localparam logic [3:0] S_OUT  = 4'd4;

    logic [30:0] step_reg;
    logic [31:0] amin_reg;
    logic [31:0] bound_reg;
    logic signed [31:0] last_reg;
    logic [31:0] rej_cnt_reg;
    logic signed [63:0] excess_reg;

    logic [3:0]  state_reg;
    logic [3:0]  op_reg;
    logic signed [63:0] h_reg, v_reg, a_reg, d_reg, a1_reg, a2_reg;
    logic signed [63:0] t1_reg, v1_reg, v2_reg, stop_reg;
    logic signed [63:0] m_vd_reg, m_ad_reg, m_add_reg, m_vt_reg, m_at_reg, m_att_reg;
    logic signed [63:0] m_v1d_reg, m_a2d_reg, m_a2dd_reg;
    logic signed [63:0] first_reg, hgt_reg;
    logic [135:0] out_reg;
    logic         out_valid_reg;

    logic        mstart, mdone;
    logic signed [63:0] mx, my, mp;
    logic        dstart, ddone;
    logic [63:0] dq;
    logic [63:0] vsq;
    logic [31:0] amin_mag;

    assign amin_mag = 32'd0 - amin_reg;

    vass_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mstart), .a(mx), .b(my),
        .done(mdone), .p(mp)
    );

    vass_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dstart),
        .num(vsq), .den({31'd0, amin_mag, 1'b0}),
        .done(ddone), .q(dq)
    );

    // operand selection per multiply step
    always_comb begin
        mx = v_reg;
        my = d_reg;
        unique case (op_reg)
            4'd0: begin mx = v_reg;     my = d_reg; end
            4'd1: begin mx = a1_reg;    my = d_reg; end
            4'd2: begin mx = m_ad_reg;  my = d_reg; end
            4'd3: begin mx = v_reg;     my = t1_reg; end
            4'd4: begin mx = a1_reg;    my = t1_reg; end
            4'd5: begin mx = m_at_reg;  my = t1_reg; end
            4'd6: begin mx = v1_reg;    my = d_reg; end
            4'd7: begin mx = a2_reg;    my = d_reg; end
            4'd8: begin mx = m_a2d_reg; my = d_reg; end
            4'd9: begin mx = v2_reg;    my = v2_reg; end
            default: begin mx = v_reg;  my = d_reg; end
        endcase
    end

    assign vsq = m_vt_reg;
    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;
    assign pready   = 1'b1;

    logic signed [63:0] h_next, tr0, tr1, tr2;
    logic rej;
    logic signed [31:0] granted;
    logic signed [64:0] diff, esum;
    logic signed [63:0] ex_next;

    always_comb begin
        tr0 = vass_pkg::sadd(m_vd_reg, mp >>> 1);
        tr1 = vass_pkg::sadd(m_vt_reg, m_att_reg >>> 1);
        tr2 = vass_pkg::sadd(m_v1d_reg, m_a2dd_reg >>> 1);
        h_next = vass_pkg::sadd(vass_pkg::sadd(vass_pkg::sadd(h_reg, first_reg), tr2),
                                stop_reg);
        rej = !(hgt_reg <= $signed({{32{bound_reg[31]}}, bound_reg}));
        granted = rej ? amin_reg : a_reg[31:0];
        diff = {a_reg[63], a_reg} - {{33{amin_reg[31]}}, amin_reg};
        esum = {excess_reg[63], excess_reg} + diff;
        if (esum > $signed({1'b0, 64'h7FFF_FFFF_FFFF_FFFF}))
            ex_next = 64'sh7FFF_FFFF_FFFF_FFFF;
        else if (esum < $signed({1'b1, 64'h8000_0000_0000_0000}))
            ex_next = 64'sh8000_0000_0000_0000;
        else
            ex_next = esum[63:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= vass_pkg::STEP_RST;
            amin_reg      <= vass_pkg::AMIN_RST;
            bound_reg     <= vass_pkg::BOUND_RST;
            last_reg      <= '0;
            rej_cnt_reg   <= '0;
            excess_reg    <= '0;
            state_reg     <= S_IDLE;
            op_reg        <= '0;
            out_valid_reg <= 1'b0;
            mstart        <= 1'b0;
            dstart        <= 1'b0;
        end else begin
            mstart <= 1'b0;
            dstart <= 1'b0;
            if (psel && penable && pwrite) begin
                unique case (paddr[3:2])
                    vass_pkg::REG_STEP:  step_reg  <= pwdata[30:0];
                    vass_pkg::REG_AMIN:  amin_reg  <= pwdata;
                    vass_pkg::REG_BOUND: bound_reg <= pwdata;
                    default: ;
                endcase
            end
            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        h_reg  <= {{32{s_tdata[31]}}, s_tdata[31:0]};
                        v_reg  <= {{32{s_tdata[63]}}, s_tdata[63:32]};
                        a_reg  <= {{32{s_tdata[95]}}, s_tdata[95:64]};
                        a2_reg <= s_tdata[95] ? 64'sd0 : {32'd0, s_tdata[95:64]};
                        d_reg  <= {33'd0, step_reg};
                        a1_reg <= last_reg[31] ? 64'sd0 : {32'd0, last_reg};
                        op_reg <= 4'd0;
                        mstart <= 1'b1;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (mdone) begin
                        unique case (op_reg)
                            4'd0: m_vd_reg  <= mp;
                            4'd1: m_ad_reg  <= mp;
                            4'd2: begin
                                m_add_reg <= mp;
                                t1_reg <= tr0[63] ? 64'sd0 : d_reg;
                                v1_reg <= vass_pkg::sadd(v_reg, m_ad_reg);
                            end
                            4'd3: m_vt_reg  <= mp;
                            4'd4: m_at_reg  <= mp;
                            4'd5: m_att_reg <= mp;
                            4'd6: begin
                                m_v1d_reg <= mp;
                                first_reg <= tr1[63] ? 64'sd0 : tr1;
                            end
                            4'd7: begin
                                m_a2d_reg <= mp;
                                v2_reg <= vass_pkg::sadd(v1_reg, mp);
                            end
                            4'd8: m_a2dd_reg <= mp;
                            4'd9: m_vt_reg   <= mp;
                            default: ;
                        endcase
                        if (op_reg == 4'd9) begin
                            if (amin_reg[31]) begin
                                dstart <= 1'b1;
                                state_reg <= S_DIV;
                            end else begin
                                stop_reg <= {1'b0, vass_pkg::SATMAX};
                                state_reg <= S_FIN;
                            end
                        end else begin
                            op_reg <= op_reg + 4'd1;
                            mstart <= 1'b1;
                        end
                    end
                end
                S_DIV: begin
                    if (ddone) begin
                        stop_reg  <= dq;
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: begin
                    hgt_reg   <= h_next;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!out_valid_reg) begin
                        last_reg <= granted;
                        if (rej) begin
                            if (rej_cnt_reg != 32'hFFFF_FFFF)
                                rej_cnt_reg <= rej_cnt_reg + 32'd1;
                            excess_reg <= ex_next;
                        end
                        out_reg <= {7'd0, (rej ? ex_next : excess_reg),
                                    (rej && rej_cnt_reg != 32'hFFFF_FFFF)
                                        ? rej_cnt_reg + 32'd1 : rej_cnt_reg,
                                    rej, granted};
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            vass_pkg::REG_STEP:  prdata = {1'b0, step_reg};
            vass_pkg::REG_AMIN:  prdata = amin_reg;
            vass_pkg::REG_BOUND: prdata = bound_reg;
            default:             prdata = '0;
        endcase
    end

endmodule
